// ===== sv/hvfm_pkg.sv =====
// ----------------------------------------------------------------------------
// hvfm_pkg
// Shared types, limits and register codes of the HV supply fast fault monitor.
// ----------------------------------------------------------------------------
package hvfm_pkg;

   localparam int unsigned NUM_COND   = 10;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 10;

   localparam logic [CNT_W-1:0] CNT_MAX                = '1;
   localparam logic [CNT_W-1:0] PERSIST_LIMIT          = 16'd4;
   localparam logic [CNT_W-1:0] TUBE_ARC_PERSIST_LIMIT = 16'd10;
   localparam logic [CNT_W-1:0] STRIKE_LIMIT           = 16'd3;

   // arc threshold sits this many kV below the target
   localparam int unsigned ARC_MARGIN_KV = 5;
   // voltage wire break below 1 kV, current wire break below 0.1 mA
   localparam int unsigned HV_BREAK_KV   = 1;
   localparam int unsigned I_BREAK_UNITS = 1;
   // half samples to tube voltage, mA to 0.1 mA
   localparam int unsigned HV_SCALE  = 2;
   localparam int unsigned CUR_SCALE = 10;

   localparam logic [7:0] VOLTAGE_MAX_RST    = 8'd140;
   localparam logic [7:0] VOLTAGE_MIN_RST    = 8'd50;
   localparam logic [9:0] CURRENT_MAX_RST    = 10'd145;
   localparam logic [9:0] CURRENT_MIN_RST    = 10'd5;
   localparam logic [5:0] FILAMENT_MAX_RST   = 6'd30;
   localparam logic [5:0] FILAMENT_MIN_RST   = 6'd8;
   localparam logic [7:0] VOLTAGE_TARGET_RST = 8'd60;

   localparam int unsigned C_KV_OVER   = 0;
   localparam int unsigned C_KV_UNDER  = 1;
   localparam int unsigned C_OIL_ARC   = 2;
   localparam int unsigned C_TUBE_ARC  = 3;
   localparam int unsigned C_HV_BREAK  = 4;
   localparam int unsigned C_MA_OVER   = 5;
   localparam int unsigned C_MA_UNDER  = 6;
   localparam int unsigned C_I_BREAK   = 7;
   localparam int unsigned C_FIL_OVER  = 8;
   localparam int unsigned C_FIL_UNDER = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLTAGE_MAX    = 3'd0,
      CSR_VOLTAGE_MIN    = 3'd1,
      CSR_CURRENT_MAX    = 3'd2,
      CSR_CURRENT_MIN    = 3'd3,
      CSR_FILAMENT_MAX   = 3'd4,
      CSR_FILAMENT_MIN   = 3'd5,
      CSR_VOLTAGE_TARGET = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0] voltage_max;
      logic [7:0] voltage_min;
      logic [9:0] current_max;
      logic [9:0] current_min;
      logic [5:0] filament_max;
      logic [5:0] filament_min;
      logic [7:0] voltage_target;
   } cfg_type;

   typedef logic [CNT_W-1:0] cnt_type;

   function automatic cnt_type sat_inc(input cnt_type v);
      return (v == CNT_MAX) ? CNT_MAX : cnt_type'(v + 1'b1);
   endfunction

endpackage

// ===== sv/hv_supply_fast_fault_monitor_top.sv =====
// ----------------------------------------------------------------------------
// hv_supply_fast_fault_monitor_top
// Fast fault monitor for a high-voltage X-ray supply.
// ----------------------------------------------------------------------------
// One sample set is taken per cycle unless rsp stalls. It is held in the input
// register; limit compares and, for enabled samples, all counter updates are
// done in the single cycle that moves it to the result register, which holds
// its fault word, so each sample sees the state left by the one before.
// Fault bits hold until reset. Limits are written through csr (always ready);
// the user must do so only while no sample is in flight; the block does not check.
module hv_supply_fast_fault_monitor_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_check_enable,
   input  logic [11:0]                         req_hv_positive,
   input  logic [11:0]                         req_hv_negative,
   input  logic [11:0]                         req_anode_current,
   input  logic [9:0]                          req_filament_voltage,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hvfm_pkg::NUM_COND-1:0]       rsp_fault_flags,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hvfm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hvfm_pkg::CSR_DATA_W-1:0]     csr_data
);

   hvfm_pkg::cfg_type                 cfg;
   logic [hvfm_pkg::NUM_COND-1:0]     cond;
   logic [hvfm_pkg::NUM_COND-1:0]     flags_next;

   logic        s1_valid_ff;
   logic        s1_enable_ff;
   logic [11:0] s1_hv_positive_ff;
   logic [11:0] s1_hv_negative_ff;
   logic [11:0] s1_anode_current_ff;
   logic [9:0]  s1_filament_voltage_ff;
   logic        rsp_valid_ff;
   logic [hvfm_pkg::NUM_COND-1:0] rsp_fault_flags_ff;
   logic        advance;
   logic        req_xfer;

   assign csr_ready = 1'b1;
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   hvfm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   hvfm_cond u_cond (
      .cfg              (cfg),
      .hv_positive      (s1_hv_positive_ff),
      .hv_negative      (s1_hv_negative_ff),
      .anode_current    (s1_anode_current_ff),
      .filament_voltage (s1_filament_voltage_ff),
      .cond             (cond)
   );

   hvfm_state u_state (
      .clock            (clock),
      .reset            (reset),
      .update           (advance && s1_enable_ff),
      .cond             (cond),
      .fault_flags_next (flags_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_enable_ff           <= req_check_enable;
         s1_hv_positive_ff      <= req_hv_positive;
         s1_hv_negative_ff      <= req_hv_negative;
         s1_anode_current_ff    <= req_anode_current;
         s1_filament_voltage_ff <= req_filament_voltage;
      end
      if (advance) begin
         rsp_fault_flags_ff <= flags_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fault_flags = rsp_fault_flags_ff;

endmodule

// ===== sv/hvfm_csr.sv =====
// ----------------------------------------------------------------------------
// hvfm_csr
// Limit and target registers, written through the csr channel.
// ----------------------------------------------------------------------------
module hvfm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [hvfm_pkg::CSR_IDX_W-1:0]      wr_index,
   input  logic [hvfm_pkg::CSR_DATA_W-1:0]     wr_data,
   output hvfm_pkg::cfg_type                   cfg
);

   hvfm_pkg::cfg_type cfg_ff;
   hvfm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (hvfm_pkg::csr_index_type'(wr_index))
            hvfm_pkg::CSR_VOLTAGE_MAX:    cfg_in.voltage_max    = wr_data[7:0];
            hvfm_pkg::CSR_VOLTAGE_MIN:    cfg_in.voltage_min    = wr_data[7:0];
            hvfm_pkg::CSR_CURRENT_MAX:    cfg_in.current_max    = wr_data[9:0];
            hvfm_pkg::CSR_CURRENT_MIN:    cfg_in.current_min    = wr_data[9:0];
            hvfm_pkg::CSR_FILAMENT_MAX:   cfg_in.filament_max   = wr_data[5:0];
            hvfm_pkg::CSR_FILAMENT_MIN:   cfg_in.filament_min   = wr_data[5:0];
            hvfm_pkg::CSR_VOLTAGE_TARGET: cfg_in.voltage_target = wr_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.voltage_max    <= hvfm_pkg::VOLTAGE_MAX_RST;
         cfg_ff.voltage_min    <= hvfm_pkg::VOLTAGE_MIN_RST;
         cfg_ff.current_max    <= hvfm_pkg::CURRENT_MAX_RST;
         cfg_ff.current_min    <= hvfm_pkg::CURRENT_MIN_RST;
         cfg_ff.filament_max   <= hvfm_pkg::FILAMENT_MAX_RST;
         cfg_ff.filament_min   <= hvfm_pkg::FILAMENT_MIN_RST;
         cfg_ff.voltage_target <= hvfm_pkg::VOLTAGE_TARGET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/hvfm_cond.sv =====
// ----------------------------------------------------------------------------
// hvfm_cond
// Compares one sample set against the limits and flags the ten conditions.
// ----------------------------------------------------------------------------
module hvfm_cond (
   input  hvfm_pkg::cfg_type                   cfg,
   input  logic [11:0]                         hv_positive,
   input  logic [11:0]                         hv_negative,
   input  logic [11:0]                         anode_current,
   input  logic [9:0]                          filament_voltage,
   output logic [hvfm_pkg::NUM_COND-1:0]       cond
);

   localparam logic [13:0] ARC_MARGIN = 14'(hvfm_pkg::ARC_MARGIN_KV * 16);
   localparam logic [12:0] HV_BREAK   = 13'(hvfm_pkg::HV_BREAK_KV * 16);
   localparam logic [15:0] I_BREAK    = 16'(hvfm_pkg::I_BREAK_UNITS * 16);

   logic [12:0]        p;
   logic [12:0]        n;
   logic signed [13:0] p_s;
   logic signed [13:0] n_s;
   logic signed [13:0] thr_s;
   logic [15:0]        cur;
   logic               p_hi, p_lo, n_hi, n_lo;

   always_comb begin
      p     = 13'(hv_positive * hvfm_pkg::HV_SCALE);
      n     = 13'(hv_negative * hvfm_pkg::HV_SCALE);
      p_s   = $signed({1'b0, p});
      n_s   = $signed({1'b0, n});
      thr_s = $signed({2'b00, cfg.voltage_target, 4'b0000}) - $signed(ARC_MARGIN);
      cur   = 16'({4'b0000, anode_current} * 16'(hvfm_pkg::CUR_SCALE));

      p_hi = p_s > thr_s;
      p_lo = p_s < thr_s;
      n_hi = n_s > thr_s;
      n_lo = n_s < thr_s;

      cond = '0;
      cond[hvfm_pkg::C_KV_OVER]   = p > {1'b0, cfg.voltage_max, 4'b0000};
      cond[hvfm_pkg::C_KV_UNDER]  = p < {1'b0, cfg.voltage_min, 4'b0000};
      cond[hvfm_pkg::C_OIL_ARC]   = (p_hi && n_lo) || (n_hi && p_lo);
      cond[hvfm_pkg::C_TUBE_ARC]  = p_lo && n_lo;
      cond[hvfm_pkg::C_HV_BREAK]  = (p < HV_BREAK) || (n < HV_BREAK);
      cond[hvfm_pkg::C_MA_OVER]   = cur > {2'b00, cfg.current_max, 4'b0000};
      cond[hvfm_pkg::C_MA_UNDER]  = cur < {2'b00, cfg.current_min, 4'b0000};
      cond[hvfm_pkg::C_I_BREAK]   = cur < I_BREAK;
      cond[hvfm_pkg::C_FIL_OVER]  = filament_voltage > {cfg.filament_max, 4'b0000};
      cond[hvfm_pkg::C_FIL_UNDER] = filament_voltage < {cfg.filament_min, 4'b0000};
   end

endmodule

// ===== sv/hvfm_state.sv =====
// ----------------------------------------------------------------------------
// hvfm_state
// Persistence and strike counters and the latched fault bits.
// ----------------------------------------------------------------------------
module hvfm_state (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                update,
   input  logic [hvfm_pkg::NUM_COND-1:0]       cond,
   output logic [hvfm_pkg::NUM_COND-1:0]       fault_flags_next
);

   localparam int unsigned NC = hvfm_pkg::NUM_COND;

   hvfm_pkg::cnt_type persist_ff [NC];
   hvfm_pkg::cnt_type persist_in [NC];
   hvfm_pkg::cnt_type oil_strike_ff;
   hvfm_pkg::cnt_type oil_strike_in;
   hvfm_pkg::cnt_type tube_strike_ff;
   hvfm_pkg::cnt_type tube_strike_in;
   logic [NC-1:0]     latched_ff;
   logic [NC-1:0]     latched_in;
   logic [NC-1:0]     latch_set;

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         persist_in[i] = cond[i] ? hvfm_pkg::sat_inc(persist_ff[i]) : '0;
         latch_set[i]  = cond[i] && (persist_in[i] > hvfm_pkg::PERSIST_LIMIT);
      end

      oil_strike_in = oil_strike_ff;
      if (cond[hvfm_pkg::C_OIL_ARC] &&
          (persist_in[hvfm_pkg::C_OIL_ARC] > hvfm_pkg::PERSIST_LIMIT)) begin
         oil_strike_in = hvfm_pkg::sat_inc(oil_strike_ff);
      end
      latch_set[hvfm_pkg::C_OIL_ARC] = cond[hvfm_pkg::C_OIL_ARC] &&
                                       (oil_strike_in >= hvfm_pkg::STRIKE_LIMIT);

      tube_strike_in = tube_strike_ff;
      if (cond[hvfm_pkg::C_TUBE_ARC] &&
          (persist_in[hvfm_pkg::C_TUBE_ARC] > hvfm_pkg::TUBE_ARC_PERSIST_LIMIT)) begin
         tube_strike_in = hvfm_pkg::sat_inc(tube_strike_ff);
      end
      latch_set[hvfm_pkg::C_TUBE_ARC] = cond[hvfm_pkg::C_TUBE_ARC] &&
                                        (tube_strike_in >= hvfm_pkg::STRIKE_LIMIT);

      latched_in       = latched_ff | latch_set;
      fault_flags_next = update ? latched_in : latched_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NC; i++) begin
            persist_ff[i] <= '0;
         end
         oil_strike_ff  <= '0;
         tube_strike_ff <= '0;
         latched_ff     <= '0;
      end else if (update) begin
         for (int i = 0; i < NC; i++) begin
            persist_ff[i] <= persist_in[i];
         end
         oil_strike_ff  <= oil_strike_in;
         tube_strike_ff <= tube_strike_in;
         latched_ff     <= latched_in;
      end
   end

endmodule

// ===== sv/hvfm_checker.sv =====
// ----------------------------------------------------------------------------
// hvfm_checker
// Port-level checks of the fault monitor, bound to the top level.
// ----------------------------------------------------------------------------
module hvfm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [hvfm_pkg::NUM_COND-1:0]       rsp_fault_flags
);

   logic [hvfm_pkg::NUM_COND-1:0] last_flags_ff;
   logic [1:0]                    inflight_ff;
   logic                          req_xfer;
   logic                          rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_flags_ff <= '0;
         inflight_ff   <= '0;
      end else begin
         if (rsp_xfer) begin
            last_flags_ff <= rsp_fault_flags;
         end
         inflight_ff <= 2'(inflight_ff + {1'b0, req_xfer} - {1'b0, rsp_xfer});
      end
   end

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_faults_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> ((rsp_fault_flags & last_flags_ff) == last_flags_ff))
      else $error("latched fault bit cleared");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (inflight_ff != 2'd0))
      else $error("rsp without a pending req");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_fault_flags)))
      else $error("stalled rsp dropped or changed");

endmodule

bind hv_supply_fast_fault_monitor_top hvfm_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_fault_flags (rsp_fault_flags)
);

// ===== tb/hv_supply_fast_fault_monitor_top_tb.sv =====
// ----------------------------------------------------------------------------
// hv_supply_fast_fault_monitor_top_tb
// Self-checking bench for the HV supply fast fault monitor. Sample sets are
// pushed through the req channel while the rsp and req sides stall at random.
// A built-in model of the persistence counters, strike counters and latched
// faults predicts every fault word. Each fault word is checked in order against
// that prediction. The limits are rewritten between phases, including the
// extremes, a target below five kV and a write to an unmapped index. The bench
// closes with a run that holds an oil arc until its fault latches.
// ----------------------------------------------------------------------------
module hv_supply_fast_fault_monitor_top_tb;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int HOLD_AT          = 200;
   localparam int HOLD_CYCLES      = 150;
   localparam int ITEMS_PER_PHASE  = 200;
   localparam int STUCK_ITEMS      = 30;
   localparam int DRAIN_CYCLES     = 4;
   localparam int OIL_STRIKE       = 0;
   localparam int TUBE_STRIKE      = 1;
   localparam logic [hvfm_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic       enable;
      logic [11:0] hv_pos;
      logic [11:0] hv_neg;
      logic [11:0] current;
      logic [9:0]  filament;
   } sample_type;

   typedef enum int {RUN_HV_POS, RUN_HV_NEG, RUN_HV_BOTH, RUN_CURRENT, RUN_FILAMENT} run_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_check_enable = 1'b0;
   logic [11:0] req_hv_positive = '0;
   logic [11:0] req_hv_negative = '0;
   logic [11:0] req_anode_current = '0;
   logic [9:0] req_filament_voltage = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [hvfm_pkg::NUM_COND-1:0] rsp_fault_flags;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [hvfm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [hvfm_pkg::CSR_DATA_W-1:0] csr_data = '0;

   sample_type samples_to_send [$];
   sample_type offered;
   logic [hvfm_pkg::NUM_COND-1:0] faults_due [$];

   hvfm_pkg::cfg_type limits = '{voltage_max: hvfm_pkg::VOLTAGE_MAX_RST,
                                 voltage_min: hvfm_pkg::VOLTAGE_MIN_RST,
                                 current_max: hvfm_pkg::CURRENT_MAX_RST,
                                 current_min: hvfm_pkg::CURRENT_MIN_RST,
                                 filament_max: hvfm_pkg::FILAMENT_MAX_RST,
                                 filament_min: hvfm_pkg::FILAMENT_MIN_RST,
                                 voltage_target: hvfm_pkg::VOLTAGE_TARGET_RST};
   hvfm_pkg::cnt_type persist_cnt [hvfm_pkg::NUM_COND] = '{default: '0};
   hvfm_pkg::cnt_type strike_cnt [2] = '{default: '0};
   logic [hvfm_pkg::NUM_COND-1:0] fault_latch = '0;

   int send_idle_pct = 18;
   int recv_idle_pct = 76;
   int rsp_count = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;

   int run_left = 0;
   run_kind_type run_kind = RUN_HV_POS;
   logic [11:0] run_value = '0;

   hv_supply_fast_fault_monitor_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_check_enable     (req_check_enable),
      .req_hv_positive      (req_hv_positive),
      .req_hv_negative      (req_hv_negative),
      .req_anode_current    (req_anode_current),
      .req_filament_voltage (req_filament_voltage),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_fault_flags      (rsp_fault_flags),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [hvfm_pkg::NUM_COND-1:0] predict_fault_word(input sample_type s);
      int p;
      int n;
      int thr;
      int cur;
      int fil;
      int k;
      hvfm_pkg::cnt_type lim;
      logic [hvfm_pkg::NUM_COND-1:0] cond;
      p = 2 * int'(s.hv_pos);
      n = 2 * int'(s.hv_neg);
      cur = 10 * int'(s.current);
      fil = int'(s.filament);
      if (s.enable) begin
         thr = int'(limits.voltage_target) * 16 - 80;
         cond = '0;
         cond[hvfm_pkg::C_KV_OVER]   = p > int'(limits.voltage_max) * 16;
         cond[hvfm_pkg::C_KV_UNDER]  = p < int'(limits.voltage_min) * 16;
         cond[hvfm_pkg::C_OIL_ARC]   = (p > thr && n < thr) || (n > thr && p < thr);
         cond[hvfm_pkg::C_TUBE_ARC]  = p < thr && n < thr;
         cond[hvfm_pkg::C_HV_BREAK]  = p < 16 || n < 16;
         cond[hvfm_pkg::C_MA_OVER]   = cur > int'(limits.current_max) * 16;
         cond[hvfm_pkg::C_MA_UNDER]  = cur < int'(limits.current_min) * 16;
         cond[hvfm_pkg::C_I_BREAK]   = cur < 16;
         cond[hvfm_pkg::C_FIL_OVER]  = fil > int'(limits.filament_max) * 16;
         cond[hvfm_pkg::C_FIL_UNDER] = fil < int'(limits.filament_min) * 16;
         for (int c = 0; c < hvfm_pkg::NUM_COND; c++) begin
            if (!cond[c]) begin
               persist_cnt[c] = '0;
            end else begin
               if (persist_cnt[c] != '1) persist_cnt[c] = persist_cnt[c] + 1'b1;
               if (c == hvfm_pkg::C_OIL_ARC || c == hvfm_pkg::C_TUBE_ARC) begin
                  k = (c == hvfm_pkg::C_TUBE_ARC) ? TUBE_STRIKE : OIL_STRIKE;
                  lim = (c == hvfm_pkg::C_TUBE_ARC) ? hvfm_pkg::TUBE_ARC_PERSIST_LIMIT
                                                    : hvfm_pkg::PERSIST_LIMIT;
                  if (persist_cnt[c] > lim && strike_cnt[k] != '1)
                     strike_cnt[k] = strike_cnt[k] + 1'b1;
                  if (strike_cnt[k] >= hvfm_pkg::STRIKE_LIMIT) fault_latch[c] = 1'b1;
               end else if (persist_cnt[c] > hvfm_pkg::PERSIST_LIMIT) begin
                  fault_latch[c] = 1'b1;
               end
            end
         end
      end
      return fault_latch;
   endfunction

   function automatic void queue_sample(input logic en, input int hp, input int hn,
                                        input int cur, input int fil);
      sample_type s;
      s.enable = en;
      s.hv_pos = hp[11:0];
      s.hv_neg = hn[11:0];
      s.current = cur[11:0];
      s.filament = fil[9:0];
      samples_to_send.push_back(s);
   endfunction

   function automatic sample_type healthy_sample();
      sample_type s;
      int lo;
      int hi;
      s.enable = 1'b1;
      s.hv_pos = 12'(int'(limits.voltage_target) * 8 + $urandom_range(12, 0));
      s.hv_neg = 12'(int'(limits.voltage_target) * 8 + $urandom_range(12, 0));
      lo = int'(limits.current_min) * 16 / 10 + 1;
      if (lo < 2) lo = 2;
      hi = int'(limits.current_max) * 16 / 10 - 1;
      if (hi < lo) hi = lo;
      s.current = 12'($urandom_range(hi, lo));
      lo = int'(limits.filament_min) * 16;
      hi = int'(limits.filament_max) * 16;
      if (hi < lo) hi = lo;
      s.filament = 10'($urandom_range(hi, lo));
      return s;
   endfunction

   function automatic sample_type next_sample();
      sample_type s;
      s = healthy_sample();
      if (run_left == 0 && $urandom_range(99, 0) < 15) begin
         run_kind = run_kind_type'($urandom_range(4, 0));
         run_value = 12'($urandom_range(4095, 0));
         run_left = ($urandom_range(3, 0) == 0) ? $urandom_range(14, 5) : $urandom_range(4, 1);
      end
      if (run_left != 0) begin
         run_left--;
         case (run_kind)
            RUN_HV_POS:  s.hv_pos = run_value;
            RUN_HV_NEG:  s.hv_neg = run_value;
            RUN_HV_BOTH: begin
               s.hv_pos = run_value;
               s.hv_neg = run_value;
            end
            RUN_CURRENT: s.current = run_value;
            default:     s.filament = run_value[9:0];
         endcase
      end
      if ($urandom_range(99, 0) < 5) begin
         s.enable = 1'($urandom_range(1, 0));
         s.hv_pos = 12'($urandom_range(4095, 0));
         s.hv_neg = 12'($urandom_range(4095, 0));
         s.current = 12'($urandom_range(4095, 0));
         s.filament = 10'($urandom_range(1023, 0));
      end
      if ($urandom_range(99, 0) < 5) s.enable = 1'b0;
      return s;
   endfunction

   task automatic write_limit(input logic [hvfm_pkg::CSR_IDX_W-1:0] idx,
                              input logic [hvfm_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         hvfm_pkg::CSR_VOLTAGE_MAX:    limits.voltage_max = data[7:0];
         hvfm_pkg::CSR_VOLTAGE_MIN:    limits.voltage_min = data[7:0];
         hvfm_pkg::CSR_CURRENT_MAX:    limits.current_max = data[9:0];
         hvfm_pkg::CSR_CURRENT_MIN:    limits.current_min = data[9:0];
         hvfm_pkg::CSR_FILAMENT_MAX:   limits.filament_max = data[5:0];
         hvfm_pkg::CSR_FILAMENT_MIN:   limits.filament_min = data[5:0];
         hvfm_pkg::CSR_VOLTAGE_TARGET: limits.voltage_target = data[7:0];
         default: ;
      endcase
   endtask

   task automatic set_limits(input int vmax, input int vmin,
                             input int cmax, input int cmin,
                             input int fmax, input int fmin,
                             input int target);
      write_limit(hvfm_pkg::CSR_VOLTAGE_MAX, 10'(vmax));
      write_limit(hvfm_pkg::CSR_VOLTAGE_MIN, 10'(vmin));
      write_limit(hvfm_pkg::CSR_CURRENT_MAX, 10'(cmax));
      write_limit(hvfm_pkg::CSR_CURRENT_MIN, 10'(cmin));
      write_limit(hvfm_pkg::CSR_FILAMENT_MAX, 10'(fmax));
      write_limit(hvfm_pkg::CSR_FILAMENT_MIN, 10'(fmin));
      write_limit(hvfm_pkg::CSR_VOLTAGE_TARGET, 10'(target));
   endtask

   task automatic wait_idle();
      while (samples_to_send.size() != 0 || req_valid || faults_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic log_failure(input string msg);
      if (fail_count < 10) $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   // sender: hold the payload until the transfer, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) faults_due.push_back(predict_fault_word(offered));
         if (!req_valid || req_ready) begin
            if (samples_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               offered = samples_to_send.pop_front();
               req_valid <= 1'b1;
               req_check_enable <= offered.enable;
               req_hv_positive <= offered.hv_pos;
               req_hv_negative <= offered.hv_neg;
               req_anode_current <= offered.current;
               req_filament_voltage <= offered.filament;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count <= rsp_count + 1;
         if (faults_due.size() == 0) begin
            log_failure($sformatf("unexpected fault word %h", rsp_fault_flags));
         end else if (rsp_fault_flags !== faults_due[0]) begin
            log_failure($sformatf("fault_flags expected %h got %h",
                                  faults_due[0], rsp_fault_flags));
            void'(faults_due.pop_front());
         end else begin
            void'(faults_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("hv_supply_fast_fault_monitor_top_tb: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      sample_type stuck;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      queue_sample(1'b1, 480, 480, 80, 320);
      queue_sample(1'b0, 4095, 4095, 4095, 1023);
      queue_sample(1'b0, 0, 0, 0, 0);
      queue_sample(1'b1, 4095, 4095, 4095, 1023);
      queue_sample(1'b1, 0, 0, 0, 0);
      queue_sample(1'b1, 440, 440, 80, 320);
      queue_sample(1'b1, 480, 400, 80, 320);
      queue_sample(1'b1, 400, 480, 80, 320);
      queue_sample(1'b1, 400, 400, 80, 320);
      queue_sample(1'b1, 7, 480, 80, 320);
      queue_sample(1'b1, 480, 8, 80, 320);
      queue_sample(1'b1, 1120, 1120, 80, 320);
      queue_sample(1'b1, 1121, 1121, 80, 320);
      queue_sample(1'b1, 400, 400, 80, 320);
      queue_sample(1'b1, 399, 399, 80, 320);
      queue_sample(1'b1, 480, 480, 232, 320);
      queue_sample(1'b1, 480, 480, 233, 320);
      queue_sample(1'b1, 480, 480, 8, 320);
      queue_sample(1'b1, 480, 480, 7, 320);
      queue_sample(1'b1, 480, 480, 1, 320);
      queue_sample(1'b1, 480, 480, 2, 320);
      queue_sample(1'b1, 480, 480, 80, 480);
      queue_sample(1'b1, 480, 480, 80, 481);
      queue_sample(1'b1, 480, 480, 80, 128);
      queue_sample(1'b1, 480, 480, 80, 127);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 76;
            recv_idle_pct = 18;
         end
         if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            1: set_limits($urandom_range(255, 100), $urandom_range(80, 0),
                          $urandom_range(1023, 100), $urandom_range(20, 0),
                          $urandom_range(63, 20), $urandom_range(10, 0),
                          $urandom_range(200, 60));
            2: set_limits($urandom_range(255, 100), $urandom_range(80, 0),
                          $urandom_range(1023, 100), $urandom_range(20, 0),
                          $urandom_range(63, 20), $urandom_range(10, 0), 3);
            3: set_limits($urandom_range(1023, 0), $urandom_range(1023, 0),
                          $urandom_range(1023, 0), $urandom_range(1023, 0),
                          $urandom_range(1023, 0), $urandom_range(1023, 0),
                          $urandom_range(1023, 0));
            4: begin
               set_limits(255, 255, 1023, 1023, 63, 63, 255);
               write_limit(CSR_UNMAPPED, 10'($urandom_range(1023, 0)));
            end
            5: set_limits(0, 0, 0, 0, 0, 0, 5);
            default: ;
         endcase
         repeat (ITEMS_PER_PHASE) samples_to_send.push_back(next_sample());
         wait_idle();
      end

      // hold an oil arc with every breakable limit exceeded until the arc fault latches
      set_limits(int'(hvfm_pkg::VOLTAGE_MAX_RST), int'(hvfm_pkg::VOLTAGE_MIN_RST),
                 int'(hvfm_pkg::CURRENT_MAX_RST), int'(hvfm_pkg::CURRENT_MIN_RST),
                 int'(hvfm_pkg::FILAMENT_MAX_RST), int'(hvfm_pkg::FILAMENT_MIN_RST),
                 int'(hvfm_pkg::VOLTAGE_TARGET_RST));
      stuck.enable = 1'b1;
      stuck.hv_pos = 12'd4095;
      stuck.hv_neg = 12'd0;
      stuck.current = 12'd0;
      stuck.filament = 10'd1023;
      repeat (STUCK_ITEMS) samples_to_send.push_back(stuck);
      wait_idle();

      if (fail_count == 0) begin
         $display("hv_supply_fast_fault_monitor_top_tb: PASS");
      end else begin
         $display("hv_supply_fast_fault_monitor_top_tb: FAIL");
      end
      $finish;
   end

endmodule
